// ===== src/nbtw_pkg.sv =====
// package: payload types, tag codes, byte roles and shared helpers for the nbt tag walker
package nbtw_pkg;

   localparam int MAX_DEPTH_DEF  = 16;
   localparam int NAME_BYTES_DEF = 16;

   localparam int FRAME_W = 41;

   // tag type codes
   localparam logic [7:0] TAG_END      = 8'd0;
   localparam logic [7:0] TAG_BYTEARR  = 8'd7;
   localparam logic [7:0] TAG_STRING   = 8'd8;
   localparam logic [7:0] TAG_LIST     = 8'd9;
   localparam logic [7:0] TAG_COMPOUND = 8'd10;
   localparam logic [7:0] TAG_LAST_FIXED = 8'd6;

   // byte roles
   localparam logic [2:0] ROLE_TYPE     = 3'd0;
   localparam logic [2:0] ROLE_NAMELEN  = 3'd1;
   localparam logic [2:0] ROLE_NAME     = 3'd2;
   localparam logic [2:0] ROLE_LENGTH   = 3'd3;
   localparam logic [2:0] ROLE_LISTTYPE = 3'd4;
   localparam logic [2:0] ROLE_PAYLOAD  = 3'd5;
   localparam logic [2:0] ROLE_END      = 3'd6;
   localparam logic [2:0] ROLE_IGNORED  = 3'd7;

   // configuration register indexes
   localparam logic [1:0] CSR_NAME_LEN  = 2'd0;
   localparam logic [1:0] CSR_NAME_LOW  = 2'd1;
   localparam logic [1:0] CSR_NAME_HIGH = 2'd2;
   localparam logic [1:0] CSR_DEPTH     = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [2:0] byte_role;
      logic [7:0] tag_type;
      logic [4:0] nest_depth;
      logic       name_hit;
      logic       hit_payload;
      logic       parse_error;
      logic       parse_done;
   } rsp_payload_type;

   typedef struct packed {
      logic        is_list;
      logic [7:0]  elem;
      logic [31:0] left;
   } frame_type;

   typedef struct packed {
      logic step;
      logic walk;
      logic reload;
   } cmd_type;

   typedef struct packed {
      logic need_walk;
      logic need_pop;
      logic walk_pop;
   } status_type;

   // log2 of the payload size of fixed-size types 1..6
   function automatic logic [1:0] size_shift(input logic [7:0] t);
      logic [1:0] s;
      s = 2'd0;
      case (t)
         8'd1: s = 2'd0;
         8'd2: s = 2'd1;
         8'd3: s = 2'd2;
         8'd4: s = 2'd3;
         8'd5: s = 2'd2;
         8'd6: s = 2'd3;
         default: s = 2'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== src/nbtw_ram.sv =====
// generic single write port ram with registered read
module nbtw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== src/nbtw_ctrl.sv =====
// controller: byte accept, walk and stack reload sequencing, result valid
module nbtw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nbtw_pkg::cmd_type    cmd,
   input  nbtw_pkg::status_type status
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_POPW = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept, emit;

   assign req_ready = (state_ff == S_IDLE) && (!valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in   = state_ff;
      emit       = 1'b0;
      cmd.step   = 1'b0;
      cmd.walk   = 1'b0;
      cmd.reload = 1'b0;
      case (state_ff)
         S_IDLE: begin
            cmd.step = accept;
            if (accept) begin
               if (status.need_pop) begin
                  state_in = S_POPW;
               end else if (status.need_walk) begin
                  state_in = S_WALK;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         S_POPW: begin
            cmd.reload = 1'b1;
            state_in   = S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_pop) begin
               state_in = S_POPW;
            end else begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      valid_in = (valid_ff && !rsp_ready) || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule

// ===== src/nbtw_datapath.sv =====
// datapath: walk registers, frame stack, name compare, configuration and result register
module nbtw_datapath #(
   parameter int MAX_DEPTH  = nbtw_pkg::MAX_DEPTH_DEF,
   parameter int NAME_BYTES = nbtw_pkg::NAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  nbtw_pkg::req_payload_type req_payload,
   output nbtw_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [63:0]               csr_wdata,
   input  nbtw_pkg::cmd_type         cmd,
   output nbtw_pkg::status_type      status
);
   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int AW = $clog2(MAX_DEPTH);

   localparam logic [3:0] PH_TYPE     = 4'd0;
   localparam logic [3:0] PH_NAMELEN  = 4'd1;
   localparam logic [3:0] PH_NAME     = 4'd2;
   localparam logic [3:0] PH_ARRLEN   = 4'd3;
   localparam logic [3:0] PH_LISTTYPE = 4'd4;
   localparam logic [3:0] PH_LISTLEN  = 4'd5;
   localparam logic [3:0] PH_PAYLOAD  = 4'd6;
   localparam logic [3:0] PH_IGNORE   = 4'd7;

   logic [4:0]  name_len_ff;
   logic [63:0] name_low_ff, name_high_ff;
   logic [4:0]  match_depth_ff;

   logic [LW-1:0]       lvl_ff, lvl_in;
   logic [3:0]          phase_ff, phase_in;
   logic [7:0]          kind_ff, kind_in;
   logic [34:0]         cnt_ff, cnt_in;
   logic [31:0]         shft_ff, shft_in;
   logic [4:0]          nidx_ff, nidx_in;
   logic                neq_ff, neq_in;
   logic                hit_ff, hit_in;
   logic                err_ff, err_in;
   logic                done_ff, done_in;
   logic [7:0]          lelem_ff, lelem_in;
   logic                begin_ff, begin_in;
   nbtw_pkg::frame_type top_ff, top_in;
   nbtw_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   nbtw_pkg::frame_type ram_wdata, ram_rdata;
   logic [nbtw_pkg::FRAME_W-1:0] ram_rdata_raw;

   logic [127:0] name_all;
   assign name_all = {name_high_ff, name_low_ff};

   nbtw_ram #(
      .WIDTH (nbtw_pkg::FRAME_W),
      .DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );
   assign ram_rdata = ram_rdata_raw;

   always_comb begin
      logic [7:0]    b;
      logic [LW-1:0] lvl_m1;
      logic          lvl_is_md;
      logic          in_hit;
      logic          hit;
      logic [2:0]    role;
      logic [7:0]    ttype;
      logic [4:0]    depth;
      logic [7:0]    bv_t;
      logic          bv_do;
      logic          push_do;
      logic          push_list;
      logic [7:0]    push_elem;
      logic [31:0]   push_cnt;
      logic          push_ok;
      logic [7:0]    match_b;

      lvl_in   = lvl_ff;   phase_in = phase_ff; kind_in  = kind_ff;
      cnt_in   = cnt_ff;   shft_in  = shft_ff;  nidx_in  = nidx_ff;
      neq_in   = neq_ff;   hit_in   = hit_ff;   err_in   = err_ff;
      done_in  = done_ff;  lelem_in = lelem_ff; begin_in = begin_ff;
      top_in   = top_ff;   rsp_in   = rsp_ff;
      status   = '0;
      ram_we   = 1'b0;
      ram_waddr = '0;
      ram_wdata = top_ff;
      ram_raddr = '0;
      b        = req_payload.data_byte;
      hit      = 1'b0;
      role     = nbtw_pkg::ROLE_IGNORED;
      ttype    = 8'd0;
      bv_do    = 1'b0;
      bv_t     = 8'd0;
      push_do  = 1'b0;
      push_list = 1'b0;
      push_elem = 8'd0;
      push_cnt = 32'd0;
      push_ok  = 1'b0;
      lvl_m1   = '0;
      match_b  = 8'd0;

      // restart clears the walk before the byte is taken
      if (cmd.step && req_payload.first_byte) begin
         lvl_in = '0; phase_in = PH_TYPE; kind_in = 8'd0; cnt_in = '0;
         shft_in = '0; nidx_in = '0; neq_in = 1'b0; hit_in = 1'b0;
         err_in = 1'b0; done_in = 1'b0; lelem_in = 8'd0; begin_in = 1'b0;
      end
      depth     = 5'(lvl_in);
      in_hit    = hit_in;
      lvl_is_md = ({5'b0, lvl_in} == {{LW{1'b0}}, match_depth_ff});

      if (cmd.step) begin
         case (phase_in)
            PH_TYPE: begin
               ttype = b;
               if (b == nbtw_pkg::TAG_END) begin
                  role = nbtw_pkg::ROLE_END;
                  if (lvl_in != '0) begin
                     lvl_in          = lvl_in - LW'(1);
                     lvl_m1          = lvl_in - LW'(1);
                     ram_raddr       = lvl_m1[AW-1:0];
                     status.need_pop = 1'b1;
                  end else begin
                     status.need_walk = 1'b1;
                  end
               end else begin
                  role     = nbtw_pkg::ROLE_TYPE;
                  kind_in  = b;
                  nidx_in  = 5'd2;
                  shft_in  = '0;
                  phase_in = PH_NAMELEN;
               end
            end
            PH_NAMELEN: begin
               role    = nbtw_pkg::ROLE_NAMELEN;
               ttype   = kind_in;
               shft_in = {16'd0, shft_in[7:0], b};
               nidx_in = nidx_in - 5'd1;
               if (nidx_in == 5'd0) begin
                  neq_in = (shft_in[15:0] == {11'd0, name_len_ff}) &&
                           (name_len_ff <= 5'(NAME_BYTES)) && lvl_is_md;
                  if (shft_in == 32'd0) begin
                     if (neq_in) begin
                        hit = 1'b1; hit_in = 1'b1;
                     end
                     bv_do = 1'b1; bv_t = kind_in;
                  end else begin
                     cnt_in   = {3'd0, shft_in};
                     nidx_in  = 5'd0;
                     phase_in = PH_NAME;
                  end
               end
            end
            PH_NAME: begin
               role    = nbtw_pkg::ROLE_NAME;
               ttype   = kind_in;
               match_b = name_all[{nidx_in[3:0], 3'd0} +: 8];
               if (neq_in && (b != match_b)) begin
                  neq_in = 1'b0;
               end
               if (nidx_in != 5'd31) begin
                  nidx_in = nidx_in + 5'd1;
               end
               cnt_in = cnt_in - 35'd1;
               if (cnt_in == '0) begin
                  if (neq_in) begin
                     hit = 1'b1; hit_in = 1'b1;
                  end
                  bv_do = 1'b1; bv_t = kind_in;
               end
            end
            PH_ARRLEN: begin
               role    = nbtw_pkg::ROLE_LENGTH;
               ttype   = kind_in;
               shft_in = {shft_in[23:0], b};
               nidx_in = nidx_in - 5'd1;
               if (nidx_in == 5'd0) begin
                  if (shft_in == 32'd0) begin
                     status.need_walk = 1'b1;
                  end else begin
                     cnt_in   = {3'd0, shft_in};
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_LISTTYPE: begin
               role     = nbtw_pkg::ROLE_LISTTYPE;
               ttype    = nbtw_pkg::TAG_LIST;
               lelem_in = b;
               nidx_in  = 5'd4;
               shft_in  = '0;
               phase_in = PH_LISTLEN;
            end
            PH_LISTLEN: begin
               role    = nbtw_pkg::ROLE_LENGTH;
               ttype   = nbtw_pkg::TAG_LIST;
               shft_in = {shft_in[23:0], b};
               nidx_in = nidx_in - 5'd1;
               if (nidx_in == 5'd0) begin
                  if ((shft_in == 32'd0) || (lelem_in == nbtw_pkg::TAG_END) ||
                      (lelem_in > nbtw_pkg::TAG_COMPOUND)) begin
                     status.need_walk = 1'b1;
                  end else if (lelem_in <= nbtw_pkg::TAG_LAST_FIXED) begin
                     kind_in  = lelem_in;
                     cnt_in   = {3'd0, shft_in} << nbtw_pkg::size_shift(lelem_in);
                     phase_in = PH_PAYLOAD;
                  end else begin
                     // first element starts in the walk cycle that follows
                     push_do   = 1'b1;
                     push_list = 1'b1;
                     push_elem = lelem_in;
                     push_cnt  = shft_in;
                  end
               end
            end
            PH_PAYLOAD: begin
               role  = nbtw_pkg::ROLE_PAYLOAD;
               ttype = kind_in;
               if (cnt_in <= 35'd1) begin
                  cnt_in           = '0;
                  status.need_walk = 1'b1;
               end else begin
                  cnt_in = cnt_in - 35'd1;
               end
            end
            default: begin
               role   = nbtw_pkg::ROLE_IGNORED;
               ttype  = 8'd0;
               in_hit = 1'b0;
            end
         endcase
      end

      if (cmd.reload) begin
         top_in = ram_rdata;
      end

      if (cmd.walk) begin
         if (begin_ff) begin
            begin_in = 1'b0;
            bv_do = 1'b1; bv_t = top_ff.elem;
         end else begin
            if (hit_in && lvl_is_md) begin
               hit_in = 1'b0;
            end
            if (lvl_in == '0) begin
               done_in  = 1'b1;
               phase_in = PH_IGNORE;
            end else if (!top_ff.is_list) begin
               phase_in = PH_TYPE;
            end else if (top_ff.left > 32'd1) begin
               top_in.left = top_ff.left - 32'd1;
               bv_do = 1'b1; bv_t = top_ff.elem;
            end else begin
               lvl_in          = lvl_in - LW'(1);
               lvl_m1          = lvl_in - LW'(1);
               ram_raddr       = lvl_m1[AW-1:0];
               status.walk_pop = 1'b1;
            end
         end
      end

      // start of a value of type bv_t
      if (bv_do) begin
         kind_in = bv_t;
         case (bv_t)
            8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6: begin
               cnt_in   = 35'd1 << nbtw_pkg::size_shift(bv_t);
               phase_in = PH_PAYLOAD;
            end
            nbtw_pkg::TAG_BYTEARR: begin
               nidx_in = 5'd4; shft_in = '0; phase_in = PH_ARRLEN;
            end
            nbtw_pkg::TAG_STRING: begin
               nidx_in = 5'd2; shft_in = '0; phase_in = PH_ARRLEN;
            end
            nbtw_pkg::TAG_LIST: begin
               phase_in = PH_LISTTYPE;
            end
            nbtw_pkg::TAG_COMPOUND: begin
               push_do = 1'b1;
            end
            default: begin
               // empty payload: value completes at once
               status.need_walk = cmd.step;
            end
         endcase
      end

      if (push_do) begin
         if (lvl_in >= LW'(MAX_DEPTH)) begin
            err_in   = 1'b1;
            hit_in   = 1'b0;
            phase_in = PH_IGNORE;
         end else begin
            lvl_m1 = lvl_in - LW'(1);
            if (lvl_in != '0) begin
               ram_we    = 1'b1;
               ram_waddr = lvl_m1[AW-1:0];
               ram_wdata = top_in;
            end
            top_in.is_list = push_list;
            top_in.elem    = push_elem;
            top_in.left    = push_cnt;
            lvl_in         = lvl_in + LW'(1);
            push_ok        = 1'b1;
         end
         if (push_list) begin
            if (push_ok) begin
               begin_in         = 1'b1;
               status.need_walk = 1'b1;
            end
         end else if (push_ok) begin
            phase_in = PH_TYPE;
         end
      end

      if (cmd.step) begin
         rsp_in.byte_out    = b;
         rsp_in.byte_role   = role;
         rsp_in.tag_type    = ttype;
         rsp_in.nest_depth  = depth;
         rsp_in.name_hit    = hit;
         rsp_in.hit_payload = in_hit;
      end
      if (cmd.step || cmd.walk) begin
         rsp_in.parse_error = err_in;
         rsp_in.parse_done  = done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_len_ff    <= 5'd0;
         name_low_ff    <= 64'd0;
         name_high_ff   <= 64'd0;
         match_depth_ff <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            nbtw_pkg::CSR_NAME_LEN:  name_len_ff    <= csr_wdata[4:0];
            nbtw_pkg::CSR_NAME_LOW:  name_low_ff    <= csr_wdata;
            nbtw_pkg::CSR_NAME_HIGH: name_high_ff   <= csr_wdata;
            nbtw_pkg::CSR_DEPTH:     match_depth_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff   <= '0;
         phase_ff <= PH_TYPE;
         kind_ff  <= 8'd0;
         cnt_ff   <= '0;
         shft_ff  <= '0;
         nidx_ff  <= '0;
         neq_ff   <= 1'b0;
         hit_ff   <= 1'b0;
         err_ff   <= 1'b0;
         done_ff  <= 1'b0;
         lelem_ff <= 8'd0;
         begin_ff <= 1'b0;
      end else begin
         lvl_ff   <= lvl_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         cnt_ff   <= cnt_in;
         shft_ff  <= shft_in;
         nidx_ff  <= nidx_in;
         neq_ff   <= neq_in;
         hit_ff   <= hit_in;
         err_ff   <= err_in;
         done_ff  <= done_in;
         lelem_ff <= lelem_in;
         begin_ff <= begin_in;
      end
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;
endmodule

// ===== src/nbt_tag_stream_walker_top.sv =====
// top level of the nbt tag stream walker
// walks a decompressed nbt stream one byte per item and returns one result item per byte with
// its role, tag type and nesting depth, plus name match and payload marks. an ordinary byte is
// accepted and its result appears in the output register the cycle after; a byte that
// completes a value goes through the walk loop of the controller, which checks the enclosing
// frames in turn and reloads the top frame from the stack memory for every frame popped (that
// memory has a registered read), and takes a further walk step when a list of strings, arrays,
// lists or compounds opens.
// the stack keeps up to MAX_DEPTH frames: the top one in a register, the rest in a small ram.
// configuration writes land at once and are meant to be made while the block is idle.
module nbt_tag_stream_walker_top #(
   parameter int MAX_DEPTH  = nbtw_pkg::MAX_DEPTH_DEF,
   parameter int NAME_BYTES = nbtw_pkg::NAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // byte items in
   input  logic                      req_valid,
   output logic                      req_ready,
   input  nbtw_pkg::req_payload_type req_payload,
   // result items out
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output nbtw_pkg::rsp_payload_type rsp_payload,
   // register writes
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [63:0]               csr_wdata
);
   nbtw_pkg::cmd_type    cmd;
   nbtw_pkg::status_type status;

   // sequencing: accept, walk loop, stack reload
   nbtw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // walk state, stack, name compare, result register
   nbtw_datapath #(
      .MAX_DEPTH  (MAX_DEPTH),
      .NAME_BYTES (NAME_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );
endmodule
